[hdl/c2p_pkg.sv]
// shared constants and the arctangent table for the cartesian to polar core
// no dependencies; imported by c2p_cordic, cartesian_to_polar_core and the testbench
package c2p_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  // rotator datapath
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_W     = 64;
  localparam int Z_W          = 32;
  localparam int NORM_MSB     = 60;

  // per-word quadrant flags handed from the prep stage to the rotator
  typedef struct packed {
    logic u_neg;   // x difference negative, add half a turn
    logic v_neg;   // folded y component negative
    logic zero;    // both points coincide
  } c2p_flags_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
    logic [Z_W-1:0] t;
    case (idx)
      5'd0:    t = 32'h2000_0000;
      5'd1:    t = 32'h12e4_051e;
      5'd2:    t = 32'h09fb_385b;
      5'd3:    t = 32'h0511_11d4;
      5'd4:    t = 32'h028b_0d43;
      5'd5:    t = 32'h0145_d7e1;
      5'd6:    t = 32'h00a2_f61e;
      5'd7:    t = 32'h0051_7c55;
      5'd8:    t = 32'h0028_be53;
      5'd9:    t = 32'h0014_5f2f;
      5'd10:   t = 32'h000a_2f98;
      5'd11:   t = 32'h0005_17cc;
      5'd12:   t = 32'h0002_8be6;
      5'd13:   t = 32'h0001_45f3;
      5'd14:   t = 32'h0000_a2fa;
      5'd15:   t = 32'h0000_517d;
      5'd16:   t = 32'h0000_28be;
      5'd17:   t = 32'h0000_145f;
      5'd18:   t = 32'h0000_0a30;
      5'd19:   t = 32'h0000_0518;
      5'd20:   t = 32'h0000_028c;
      5'd21:   t = 32'h0000_0146;
      5'd22:   t = 32'h0000_00a3;
      5'd23:   t = 32'h0000_0051;
      5'd24:   t = 32'h0000_0029;
      5'd25:   t = 32'h0000_0014;
      5'd26:   t = 32'h0000_000a;
      5'd27:   t = 32'h0000_0005;
      5'd28:   t = 32'h0000_0003;
      5'd29:   t = 32'h0000_0001;
      5'd30:   t = 32'h0000_0001;
      default: t = 32'h0000_0000;
    endcase
    return t;
  endfunction

endpackage

[hdl/c2p_cordic.sv]
// angle pipeline: leading-zero normalizer, unrolled vectoring cordic, rounding
// depends on c2p_pkg
module c2p_cordic import c2p_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [COORD_WIDTH-1:0] au_i,
  input  logic [COORD_WIDTH-1:0] av_i,
  input  c2p_flags_t             flags_i,
  output logic [ANGLE_WIDTH-1:0] angle_o
);

  localparam int NS  = $clog2(COORD_WIDTH);
  localparam int LSH = NORM_MSB + 1 - COORD_WIDTH;
  localparam logic [Z_W-1:0] HALF =
    (ANGLE_WIDTH < Z_W) ? (Z_W'(1) << (Z_W - 1 - ANGLE_WIDTH)) : '0;

  // normalizer stages
  logic [COORD_WIDTH-1:0] nau_q [NS];
  logic [COORD_WIDTH-1:0] nav_q [NS];
  c2p_flags_t             nfl_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int K = 1 << (NS - 1 - j);
    logic [COORD_WIDTH-1:0] au_s, av_s, m_s;
    c2p_flags_t             fl_s;
    if (j == 0) begin : g_first
      assign au_s = au_i;
      assign av_s = av_i;
      assign fl_s = flags_i;
    end else begin : g_next
      assign au_s = nau_q[j-1];
      assign av_s = nav_q[j-1];
      assign fl_s = nfl_q[j-1];
    end
    assign m_s = au_s | av_s;
    // shift by K when the top K bits of the larger magnitude are clear
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (m_s[COORD_WIDTH-1 -: K] == '0) begin
          nau_q[j] <= au_s << K;
          nav_q[j] <= av_s << K;
        end else begin
          nau_q[j] <= au_s;
          nav_q[j] <= av_s;
        end
        nfl_q[j] <= fl_s;
      end
    end
  end

  // rotator stages, index 0 is the load stage
  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS+1];
  logic        [Z_W-1:0]      z_q [CORDIC_STEPS+1];
  logic                       zr_q [CORDIC_STEPS+1];

  logic [CORDIC_W-1:0] x_ld, y_ld;
  assign x_ld = CORDIC_W'(nau_q[NS-1]) << LSH;
  assign y_ld = CORDIC_W'(nav_q[NS-1]) << LSH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= x_ld;
      y_q[0]  <= nfl_q[NS-1].v_neg ? -y_ld : y_ld;
      z_q[0]  <= nfl_q[NS-1].u_neg ? {1'b1, {(Z_W-1){1'b0}}} : '0;
      zr_q[0] <= nfl_q[NS-1].zero;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xs, ys;
    logic        [Z_W-1:0]      t;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign t  = atan_turn(5'(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][CORDIC_W-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + t;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - t;
        end
        zr_q[i+1] <= zr_q[i];
      end
    end
  end

  // round to the output width, coinciding points give zero
  logic [Z_W-1:0]         z_rnd;
  logic [ANGLE_WIDTH-1:0] angle_q;
  assign z_rnd = z_q[CORDIC_STEPS] + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zr_q[CORDIC_STEPS] ? '0 : z_rnd[Z_W-1 -: ANGLE_WIDTH];
    end
  end

  assign angle_o = angle_q;

endmodule

[hdl/cartesian_to_polar_core.sv]
// top level of the cartesian to polar core: stream ports, distance root, alignment
// depends on c2p_pkg and c2p_cordic
//
// Takes a start and an end point per input word and returns, per word, the
// Euclidean distance between them in 1/16 pixel (rounded to nearest) and the
// direction atan2(-dy, dx) as an unsigned fraction of a full turn, where
// 2^ANGLE_WIDTH is one turn; screen y grows downward, hence the flipped sign.
// Coinciding points give distance 0 and angle 0. The core is a fully
// pipelined datapath: while the master side accepts, one word is accepted per
// clock and one result leaves per clock. The shorter of the distance and angle
// paths is delayed to match the longer one, which at the default widths is the
// angle path with its 32 unrolled cordic stages.
// A stalled master side freezes the whole pipeline; nothing is dropped.
module cartesian_to_polar_core import c2p_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int DIST_W     = COORD_WIDTH + 5,
  localparam int IN_W       = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W      = ((DIST_W + ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
  // master side
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // distance, angle
);

  localparam int CW    = COORD_WIDTH;
  localparam int P     = DIST_W;            // root bits, one per root stage
  localparam int VW    = 2 * P;             // radicand bits
  localparam int RW    = P + 2;             // remainder bits
  localparam int LAT_D = P + 3;             // square, sum, root stages, round
  localparam int LAT_A = $clog2(CW) + CORDIC_STEPS + 2;
  localparam int LAT   = (LAT_D > LAT_A) ? LAT_D : LAT_A;
  localparam int DLY_D = LAT - LAT_D;
  localparam int DLY_A = LAT - LAT_A;
  localparam int OUT_IDX = LAT + 1;

  // whole pipeline moves when the output stage is empty or being drained
  logic en;
  logic v_q [OUT_IDX+1];

  assign en            = !v_q[OUT_IDX] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[OUT_IDX];

  // valid bits travel alongside the payload stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= OUT_IDX; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= s_axis_tvalid;
      for (int k = 1; k <= OUT_IDX; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: coordinate differences at full precision
  logic [CW-1:0]   start_x, start_y, end_x, end_y;
  logic signed [CW:0] dx_d, dy_d, dx_q, dy_q;

  assign start_x = s_axis_tdata[0*CW +: CW];
  assign start_y = s_axis_tdata[1*CW +: CW];
  assign end_x   = s_axis_tdata[2*CW +: CW];
  assign end_y   = s_axis_tdata[3*CW +: CW];
  assign dx_d    = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
  assign dy_d    = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 1: magnitudes, shared by both paths, and quadrant flags for the angle path
  logic signed [CW:0] adx_w, ady_w;
  logic [CW-1:0]      adx_q, ady_q;
  c2p_flags_t         fl_d, fl_q;

  assign adx_w = dx_q[CW] ? -dx_q : dx_q;
  assign ady_w = dy_q[CW] ? -dy_q : dy_q;

  always_comb begin
    fl_d.u_neg = dx_q[CW];
    // after folding into the right half plane the y part is dy or -dy
    fl_d.v_neg = dx_q[CW] ? dy_q[CW] : (!dy_q[CW] && (dy_q != '0));
    fl_d.zero  = (dx_q == '0) && (dy_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q <= adx_w[CW-1:0];
      ady_q <= ady_w[CW-1:0];
      fl_q  <= fl_d;
    end
  end

  // angle path
  logic [ANGLE_WIDTH-1:0] angle_w;

  c2p_cordic #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .au_i   (adx_q),
    .av_i   (ady_q),
    .flags_i(fl_q),
    .angle_o(angle_w)
  );

  // distance path: squares, then 256 * sum as the radicand
  logic [2*CW-1:0] sqx_q, sqy_q;
  logic [VW-1:0]   val_q  [P+1];
  logic [RW-1:0]   rem_q  [P+1];
  logic [P-1:0]    root_q [P+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q     <= adx_q * adx_q;
      sqy_q     <= ady_q * ady_q;
      val_q[0]  <= VW'({(2*CW+1)'(sqx_q) + (2*CW+1)'(sqy_q), 8'h00});
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < P; k++) begin : g_root
    logic [RW+1:0] rem_t, trial;
    assign rem_t = {rem_q[k], val_q[k][VW-1 -: 2]};
    assign trial = (RW+2)'({root_q[k], 2'b01});
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_t >= trial) begin
          rem_q[k+1]  <= RW'(rem_t - trial);
          root_q[k+1] <= {root_q[k][P-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= RW'(rem_t);
          root_q[k+1] <= {root_q[k][P-2:0], 1'b0};
        end
        val_q[k+1] <= val_q[k] << 2;
      end
    end
  end

  // round to nearest: the next root bit is one when the remainder exceeds the root
  logic [DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (rem_q[P] > RW'(root_q[P])) ? root_q[P] + 1'b1 : root_q[P];
    end
  end

  // align the shorter path to the longer one
  logic [DIST_W-1:0]      dist_out;
  logic [ANGLE_WIDTH-1:0] angle_out;

  if (DLY_D > 0) begin : g_dly_d
    logic [DIST_W-1:0] dd_q [DLY_D];
    always_ff @(posedge clk_i) begin
      if (en) begin
        dd_q[0] <= dist_q;
        for (int k = 1; k < DLY_D; k++) begin
          dd_q[k] <= dd_q[k-1];
        end
      end
    end
    assign dist_out = dd_q[DLY_D-1];
  end else begin : g_nodly_d
    assign dist_out = dist_q;
  end

  if (DLY_A > 0) begin : g_dly_a
    logic [ANGLE_WIDTH-1:0] da_q [DLY_A];
    always_ff @(posedge clk_i) begin
      if (en) begin
        da_q[0] <= angle_w;
        for (int k = 1; k < DLY_A; k++) begin
          da_q[k] <= da_q[k-1];
        end
      end
    end
    assign angle_out = da_q[DLY_A-1];
  end else begin : g_nodly_a
    assign angle_out = angle_w;
  end

  // distance in the low bits, angle above it, zero padding on top
  assign m_axis_tdata = OUT_W'({angle_out, dist_out});

endmodule

[dv/tb_cartesian_to_polar_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for cartesian_to_polar_core: point pairs in, distance and angle out
// depends on c2p_pkg and the core; predicts each result with its own integer root and cordic
module tb_cartesian_to_polar_core;
  import c2p_pkg::*;

  localparam int CW      = COORD_WIDTH_DEF;
  localparam int AW      = ANGLE_WIDTH_DEF;
  localparam int DIST_W  = CW + 5;
  localparam int IN_W    = ((4 * CW + 7) / 8) * 8;
  localparam int OUT_W   = ((DIST_W + AW + 7) / 8) * 8;
  localparam int N_RAND  = 2000;
  localparam int EXP_DEPTH = 4096;
  localparam int CALM_FROM = 600;   // no idling on either side in this stretch
  localparam int CALM_TO   = 1000;
  localparam int DRAIN_AT  = 1300;  // sender waits here until the pipe is empty
  localparam int SETTLE    = 60;

  // atan(2^-i) in 2^-32 turn, entry 0 in the low bits
  localparam logic [32*32-1:0] ATAN_STEPS = {
    32'h00000000, 32'h00000001, 32'h00000001, 32'h00000003,
    32'h00000005, 32'h0000000a, 32'h00000014, 32'h00000029,
    32'h00000051, 32'h000000a3, 32'h00000146, 32'h0000028c,
    32'h00000518, 32'h00000a30, 32'h0000145f, 32'h000028be,
    32'h0000517d, 32'h0000a2fa, 32'h000145f3, 32'h00028be6,
    32'h000517cc, 32'h000a2f98, 32'h00145f2f, 32'h0028be53,
    32'h00517c55, 32'h00a2f61e, 32'h0145d7e1, 32'h028b0d43,
    32'h051111d4, 32'h09fb385b, 32'h12e4051e, 32'h20000000
  };

  // result word layout, distance in the low bits
  typedef struct packed {
    logic [AW-1:0]     angle;
    logic [DIST_W-1:0] distance;
  } polar_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic [IN_W-1:0] point_pairs[$];
  polar_t          expected_polar [EXP_DEPTH];
  int              pairs_sent = 0;
  int              results_seen = 0;
  int              mismatches = 0;
  int              coinciding = 0;
  bit              drained = 1'b0;

  cartesian_to_polar_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // distance as round(16 * sqrt(dx^2 + dy^2)), angle as atan2(-dy, dx) via vectoring cordic
  function automatic polar_t polar_of(input logic [IN_W-1:0] pts);
    longint          dx, dy, u, v;
    logic [63:0]     adx, ady, sq, rem, root, trial, au, av, big;
    longint          x, y, xs, ys;
    logic [31:0]     z;
    logic [32:0]     zr;
    int              sh;
    polar_t          res;
    dx = longint'($signed(pts[2*CW +: CW])) - longint'($signed(pts[0 +: CW]));
    dy = longint'($signed(pts[4*CW-1 -: CW])) - longint'($signed(pts[CW +: CW]));
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;

    // bit-serial square root of 256 * (dx^2 + dy^2), then round to nearest
    sq = (adx * adx + ady * ady) << 8;
    rem = '0;
    root = '0;
    for (int p = 31; p >= 0; p--) begin
      rem = (rem << 2) | ((sq >> (2 * p)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root = root + 64'd1;
    res.distance = root[DIST_W-1:0];

    u = dx;
    v = -dy;
    if (u == 0 && v == 0) begin
      res.angle = '0;
    end else begin
      z = '0;
      // left half plane: fold over and start from half a turn
      if (u < 0) begin
        u = -u;
        v = -v;
        z = 32'h8000_0000;
      end
      au = u;
      av = (v < 0) ? -v : v;
      big = (au > av) ? au : av;
      sh = 0;
      while ((big << sh) < (64'd1 << 60)) sh++;
      x = au << sh;
      y = (v < 0) ? -(av << sh) : (av << sh);
      for (int i = 0; i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEPS[i*32 +: 32];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEPS[i*32 +: 32];
        end
      end
      zr = {1'b0, z} + (33'd1 << (31 - AW));
      res.angle = zr[31 -: AW];
    end
    return res;
  endfunction

  // sender: loads the next pair when the slave side is free, with random gaps outside the calm stretch
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic fire;
    int   sent_now;
    bit   calm, hold, gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      sent_now = pairs_sent + (fire ? 1 : 0);
      if (fire) begin
        expected_polar[pairs_sent % EXP_DEPTH] = polar_of(s_axis_tdata);
        pairs_sent <= sent_now;
      end
      if (sent_now >= DRAIN_AT && !drained && results_seen == sent_now) drained <= 1'b1;
      hold = sent_now >= DRAIN_AT && !drained && results_seen != sent_now;
      calm = sent_now >= CALM_FROM && sent_now < CALM_TO;
      gap  = !calm && ($urandom_range(99) < 20);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (point_pairs.size() != 0 && !hold && !gap) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= point_pairs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, checks each word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    polar_t got, want;
    bit     calm;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[DIST_W+AW-1:0];
        if (results_seen >= pairs_sent) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: distance %0d angle %0d",
                     $realtime, got.distance, got.angle);
        end else begin
          want = expected_polar[results_seen % EXP_DEPTH];
          if (got.distance !== want.distance || got.angle !== want.angle ||
              m_axis_tdata[OUT_W-1:DIST_W+AW] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: word %0d: distance %0d exp %0d, angle %0d exp %0d, pad %0h",
                       $realtime, results_seen, got.distance, want.distance,
                       got.angle, want.angle, m_axis_tdata[OUT_W-1:DIST_W+AW]);
          end
          results_seen <= results_seen + 1;
        end
      end
      calm = pairs_sent >= CALM_FROM && pairs_sent < CALM_TO;
      m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  task automatic add_pair(input logic [CW-1:0] sx, sy, ex, ey);
    point_pairs.push_back({ey, ex, sy, sx});
    if (sx == ex && sy == ey) coinciding++;
  endtask

  function automatic logic [CW-1:0] nudge(input logic [CW-1:0] base, input int span);
    return base + CW'($urandom_range(2 * span)) - CW'(span);
  endfunction

  initial begin : stimulus
    logic [CW-1:0] sx, sy, d;
    int            kind;

    // coinciding points
    add_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    add_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    add_pair(16'sd1234, -16'sd77, 16'sd1234, -16'sd77);
    // corner to corner, largest distance
    add_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    add_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    add_pair(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    add_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    // unit steps on the axes: right, up, left, down on screen
    add_pair(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    add_pair(16'sd0, 16'sd0, 16'sd0, -16'sd1);
    add_pair(16'sd0, 16'sd0, -16'sd1, 16'sd0);
    add_pair(16'sd0, 16'sd0, 16'sd0, 16'sd1);
    // full-span axis runs
    add_pair(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
    add_pair(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
    add_pair(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
    add_pair(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    // diagonals, a 3-4-5 triangle, a rounding case
    add_pair(16'sd0, 16'sd0, 16'sd1, 16'sd1);
    add_pair(16'sd0, 16'sd0, -16'sd1, -16'sd1);
    add_pair(16'sd0, 16'sd0, 16'sd3, -16'sd4);
    add_pair(16'sd0, 16'sd0, 16'sd1, 16'sd2);
    // just either side of angle zero, where the turn wraps
    add_pair(16'sd0, 16'sd0, 16'sd32767, 16'sd1);
    add_pair(16'sd0, 16'sd0, 16'sd32767, -16'sd1);

    for (int k = 0; k < N_RAND; k++) begin
      sx = CW'($urandom);
      sy = CW'($urandom);
      kind = $urandom_range(3);
      case (kind)
        0: add_pair(sx, sy, CW'($urandom), CW'($urandom));
        1: add_pair(sx, sy, nudge(sx, 255), nudge(sy, 255));
        2: begin
          // along an axis or a diagonal
          d = CW'($urandom);
          case ($urandom_range(3))
            0: add_pair(sx, sy, sx + d, sy);
            1: add_pair(sx, sy, sx, sy + d);
            2: add_pair(sx, sy, sx + d, sy + d);
            default: add_pair(sx, sy, sx + d, sy - d);
          endcase
        end
        default: add_pair(sx, sy, nudge(sx, 3), nudge(sy, 3));
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (point_pairs.size() != 0 || s_axis_tvalid || results_seen != pairs_sent)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("checked %0d point pairs (%0d coinciding) through axis, diagonal, near and wide",
             pairs_sent, coinciding);
    $display("random back-pressure on both sides, one drained pause, %0d mismatches",
             mismatches);
    if (mismatches == 0 && results_seen == pairs_sent) begin
      $display("[cartesian_to_polar_core] OK");
    end else begin
      $display("[cartesian_to_polar_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("timeout with %0d sent and %0d results", pairs_sent, results_seen);
    $display("[cartesian_to_polar_core] ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/c2p_pkg.sv
hdl/c2p_cordic.sv
hdl/cartesian_to_polar_core.sv
dv/tb_cartesian_to_polar_core.sv
